FILE: design/lei_pkg.sv
package lei_pkg;

   // fixed-point format and field widths
   localparam int FRAC_BITS = 24;
   localparam int COORD_W   = 32;
   localparam int COUNT_W   = 32;
   localparam int COEF_W    = 31;
   localparam int DT_W      = 24;
   localparam int PERIOD_W  = 16;
   localparam int SQ_W      = 41;

   // datapath widths
   localparam int DIFF_W  = COORD_W + 1;            // multiplier operand
   localparam int PA_W    = 2 * DIFF_W;             // coefficient / square product
   localparam int DELTA_W = PA_W - FRAC_BITS;       // derivative term
   localparam int PB_W    = DELTA_W + DT_W + 1;     // derivative times dt
   localparam int NEXT_W  = PB_W - FRAC_BITS + 1;   // coordinate before clipping
   localparam int ACC_W   = DELTA_W + 2;            // sum of three squares

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RHO    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 3'd5;

   localparam logic [COEF_W-1:0]   SIGMA_RST  = 31'd167772160;
   localparam logic [COEF_W-1:0]   RHO_RST    = 31'd469762048;
   localparam logic [COEF_W-1:0]   BETA_RST   = 31'd44739243;
   localparam logic [DT_W-1:0]     DT_RST     = 24'd167772;
   localparam logic [COUNT_W-1:0]  START_RST  = 32'd1000;
   localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd100;

   // 1.0 in the coordinate format
   localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(1) <<< FRAC_BITS;

   // item kind on the request channel
   localparam logic FUNC_STEP = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   typedef struct packed {
      logic [COEF_W-1:0]   sigma;
      logic [COEF_W-1:0]   rho;
      logic [COEF_W-1:0]   beta;
      logic [DT_W-1:0]     dt;
      logic [COUNT_W-1:0]  sample_start;
      logic [PERIOD_W-1:0] sample_period;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BZ, ST_SD, ST_XR, ST_DX, ST_DY, ST_COMMIT,
      ST_SQX, ST_SQY, ST_SQZ, ST_SQSUM, ST_MAX, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_XY, OP_BZ, OP_SD, OP_XR, OP_DX, OP_DY, OP_COMMIT,
      OP_SQX, OP_SQY, OP_SQZ, OP_SQSUM, OP_MAX
   } op_type;

   typedef struct packed {
      op_type op;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic sample_hit;
   } status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] value;
      logic                      clip;
   } sat_type;

   // clip to the signed coordinate range
   function automatic sat_type sat_coord(input logic signed [NEXT_W-1:0] v);
      sat_type                  r;
      logic [NEXT_W-COORD_W:0]  top;
      top = v[NEXT_W-1:COORD_W-1];
      if (top == '0 || top == '1) begin
         r.value = v[COORD_W-1:0];
         r.clip  = 1'b0;
      end else begin
         r.clip  = 1'b1;
         r.value = v[NEXT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                               : {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

FILE: design/lei_csr.sv
module lei_csr import lei_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SIGMA:  cfg_in.sigma         = csr_wdata[COEF_W-1:0];
            CSR_RHO:    cfg_in.rho           = csr_wdata[COEF_W-1:0];
            CSR_BETA:   cfg_in.beta          = csr_wdata[COEF_W-1:0];
            CSR_DT:     cfg_in.dt            = csr_wdata[DT_W-1:0];
            CSR_START:  cfg_in.sample_start  = csr_wdata[COUNT_W-1:0];
            CSR_PERIOD: cfg_in.sample_period = csr_wdata[PERIOD_W-1:0];
            default:    cfg_in = cfg_ff;   // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sigma         <= SIGMA_RST;
         cfg_ff.rho           <= RHO_RST;
         cfg_ff.beta          <= BETA_RST;
         cfg_ff.dt            <= DT_RST;
         cfg_ff.sample_start  <= START_RST;
         cfg_ff.sample_period <= PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/lei_ctrl.sv
module lei_ctrl import lei_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_func,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_func == FUNC_LOAD) begin
                  cmd.op   = OP_LOAD;
                  state_in = ST_OUT;
               end else begin
                  cmd.op   = OP_XY;
                  state_in = ST_BZ;
               end
            end
         end
         ST_BZ: begin
            cmd.op   = OP_BZ;
            state_in = ST_SD;
         end
         ST_SD: begin
            cmd.op   = OP_SD;
            state_in = ST_XR;
         end
         ST_XR: begin
            cmd.op   = OP_XR;
            state_in = ST_DX;
         end
         ST_DX: begin
            cmd.op   = OP_DX;
            state_in = ST_DY;
         end
         ST_DY: begin
            cmd.op   = OP_DY;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.op   = OP_COMMIT;
            state_in = status.sample_hit ? ST_SQX : ST_OUT;
         end
         ST_SQX: begin
            cmd.op   = OP_SQX;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.op   = OP_SQY;
            state_in = ST_SQZ;
         end
         ST_SQZ: begin
            cmd.op   = OP_SQZ;
            state_in = ST_SQSUM;
         end
         ST_SQSUM: begin
            cmd.op   = OP_SQSUM;
            state_in = ST_MAX;
         end
         ST_MAX: begin
            cmd.op   = OP_MAX;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   a_load_to_out: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_func == FUNC_LOAD) |=> (state_ff == ST_OUT))
      else $error("load item did not go straight to output");

   a_step_to_bz: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_func == FUNC_STEP) |=> (state_ff == ST_BZ))
      else $error("step item did not start the euler sequence");

endmodule

FILE: design/lei_dpath.sv
module lei_dpath import lei_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  cmd_type                   cmd,
   input  logic signed [COORD_W-1:0] start_x,
   input  logic signed [COORD_W-1:0] start_y,
   input  logic signed [COORD_W-1:0] start_z,
   output status_type                status,
   output logic signed [COORD_W-1:0] pos_x,
   output logic signed [COORD_W-1:0] pos_y,
   output logic signed [COORD_W-1:0] pos_z,
   output logic [COUNT_W-1:0]        step_index,
   output logic                      sampled,
   output logic                      saturated,
   output logic [SQ_W-1:0]           max_sq_distance
);

   // architectural state
   logic signed [COORD_W-1:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic signed [COORD_W-1:0] cur_x_in, cur_y_in, cur_z_in;
   logic signed [COORD_W-1:0] org_x_ff, org_y_ff, org_z_ff;
   logic signed [COORD_W-1:0] org_x_in, org_y_in, org_z_in;
   logic [COUNT_W-1:0]        cnt_ff, cnt_in;
   logic [PERIOD_W-1:0]       pc_ff, pc_in;
   logic [SQ_W-1:0]           max_ff, max_in;

   // working registers
   logic signed [PA_W-1:0]    pa_ff, pa_in;
   logic signed [PB_W-1:0]    pb_ff, pb_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [COORD_W-1:0] nx_ff, nx_in, nz_ff, nz_in;
   logic                      clip_x_ff, clip_x_in, clip_z_ff, clip_z_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic                      sampled_ff, sampled_in, sat_ff, sat_in;

   // output payload
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [COUNT_W-1:0]        out_cnt_ff;
   logic                      out_sampled_ff, out_sat_ff;
   logic [SQ_W-1:0]           out_max_ff;

   logic signed [DIFF_W-1:0]  mul_a, mul_b;
   logic signed [DELTA_W-1:0] pa_sh;
   logic signed [NEXT_W-2:0]  pb_sh;
   logic [DELTA_W-1:0]        sq_term;
   logic signed [DIFF_W-1:0]  x_ext, y_ext, z_ext;
   logic signed [DT_W:0]      dt_s;
   logic [COUNT_W-1:0]        cnt_inc;
   logic                      past_start, hit;
   logic [SQ_W-1:0]           acc_sat;
   sat_type                   sat_next;

   assign x_ext   = DIFF_W'(cur_x_ff);
   assign y_ext   = DIFF_W'(cur_y_ff);
   assign z_ext   = DIFF_W'(cur_z_ff);
   assign dt_s    = $signed({1'b0, cfg.dt});
   assign pa_sh   = $signed(pa_ff[PA_W-1:FRAC_BITS]);   // floor shift
   assign pb_sh   = $signed(pb_ff[PB_W-1:FRAC_BITS]);
   assign sq_term = pa_ff[PA_W-1:FRAC_BITS];             // squares are never negative

   // step counter holds at all ones
   assign cnt_inc    = (cnt_ff == '1) ? cnt_ff : cnt_ff + COUNT_W'(1);
   assign past_start = cnt_inc > cfg.sample_start;
   assign hit        = (cnt_inc == cfg.sample_start) || (past_start && pc_ff == '0);
   assign status.sample_hit = hit;

   assign acc_sat = (acc_ff[ACC_W-1:SQ_W] != '0) ? '1 : acc_ff[SQ_W-1:0];

   // shared coefficient / square multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_XY: begin
            mul_a = x_ext;
            mul_b = y_ext;
         end
         OP_BZ: begin
            mul_a = DIFF_W'($signed({1'b0, cfg.beta}));
            mul_b = z_ext;
         end
         OP_SD: begin
            mul_a = DIFF_W'($signed({1'b0, cfg.sigma}));
            mul_b = y_ext - x_ext;
         end
         OP_XR: begin
            mul_a = x_ext;
            mul_b = DIFF_W'($signed({1'b0, cfg.rho})) - z_ext;
         end
         OP_SQX: begin
            mul_a = x_ext - DIFF_W'(org_x_ff);
            mul_b = mul_a;
         end
         OP_SQY: begin
            mul_a = y_ext - DIFF_W'(org_y_ff);
            mul_b = mul_a;
         end
         OP_SQZ: begin
            mul_a = z_ext - DIFF_W'(org_z_ff);
            mul_b = mul_a;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign pa_in = mul_a * mul_b;
   assign pb_in = delta_ff * dt_s;

   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      cur_z_in   = cur_z_ff;
      org_x_in   = org_x_ff;
      org_y_in   = org_y_ff;
      org_z_in   = org_z_ff;
      cnt_in     = cnt_ff;
      pc_in      = pc_ff;
      max_in     = max_ff;
      delta_in   = delta_ff;
      nx_in      = nx_ff;
      nz_in      = nz_ff;
      clip_x_in  = clip_x_ff;
      clip_z_in  = clip_z_ff;
      acc_in     = acc_ff;
      sampled_in = sampled_ff;
      sat_in     = sat_ff;
      sat_next   = sat_coord(NEXT_W'(cur_y_ff) + NEXT_W'(pb_sh));
      case (cmd.op)
         OP_LOAD: begin
            cur_x_in   = start_x;
            cur_y_in   = start_y;
            cur_z_in   = start_z;
            org_x_in   = start_x;
            org_y_in   = start_y;
            org_z_in   = start_z;
            cnt_in     = '0;
            max_in     = '0;
            pc_in      = cfg.sample_period - PERIOD_W'(1);
            sampled_in = 1'b0;
            sat_in     = 1'b0;
         end
         OP_BZ:  delta_in = pa_sh;                          // x*y
         OP_SD:  delta_in = delta_ff - pa_sh;               // dz = x*y - beta*z
         OP_XR:  delta_in = pa_sh;                          // dx = sigma*(y-x)
         OP_DX: begin
            delta_in  = pa_sh - DELTA_W'(cur_y_ff);         // dy = x*(rho-z) - y
            sat_next  = sat_coord(NEXT_W'(cur_z_ff) + NEXT_W'(pb_sh));
            nz_in     = sat_next.value;
            clip_z_in = sat_next.clip;
         end
         OP_DY: begin
            sat_next  = sat_coord(NEXT_W'(cur_x_ff) + NEXT_W'(pb_sh));
            nx_in     = sat_next.value;
            clip_x_in = sat_next.clip;
         end
         OP_COMMIT: begin
            cur_x_in   = nx_ff;
            cur_y_in   = sat_next.value;
            cur_z_in   = nz_ff;
            sat_in     = clip_x_ff | clip_z_ff | sat_next.clip;
            cnt_in     = cnt_inc;
            sampled_in = hit;
            if (hit) begin
               pc_in = cfg.sample_period - PERIOD_W'(1);
            end else if (past_start) begin
               pc_in = pc_ff - PERIOD_W'(1);
            end
         end
         OP_SQY:   acc_in = ACC_W'(sq_term);
         OP_SQZ:   acc_in = acc_ff + ACC_W'(sq_term);
         OP_SQSUM: acc_in = acc_ff + ACC_W'(sq_term);
         OP_MAX: begin
            if (acc_sat > max_ff) begin
               max_in = acc_sat;
            end
         end
         default: delta_in = delta_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= COORD_ONE;
         cur_y_ff <= COORD_ONE;
         cur_z_ff <= COORD_ONE;
         org_x_ff <= COORD_ONE;
         org_y_ff <= COORD_ONE;
         org_z_ff <= COORD_ONE;
         cnt_ff   <= '0;
         pc_ff    <= '0;
         max_ff   <= '0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         cur_z_ff <= cur_z_in;
         org_x_ff <= org_x_in;
         org_y_ff <= org_y_in;
         org_z_ff <= org_z_in;
         cnt_ff   <= cnt_in;
         pc_ff    <= pc_in;
         max_ff   <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff      <= pa_in;
      pb_ff      <= pb_in;
      delta_ff   <= delta_in;
      nx_ff      <= nx_in;
      nz_ff      <= nz_in;
      clip_x_ff  <= clip_x_in;
      clip_z_ff  <= clip_z_in;
      acc_ff     <= acc_in;
      sampled_ff <= sampled_in;
      sat_ff     <= sat_in;
      if (cmd.out_load) begin
         out_x_ff       <= cur_x_ff;
         out_y_ff       <= cur_y_ff;
         out_z_ff       <= cur_z_ff;
         out_cnt_ff     <= cnt_ff;
         out_sampled_ff <= sampled_ff;
         out_sat_ff     <= sat_ff;
         out_max_ff     <= max_ff;
      end
   end

   assign pos_x           = out_x_ff;
   assign pos_y           = out_y_ff;
   assign pos_z           = out_z_ff;
   assign step_index      = out_cnt_ff;
   assign sampled         = out_sampled_ff;
   assign saturated       = out_sat_ff;
   assign max_sq_distance = out_max_ff;

   a_max_monotonic: assert property (@(posedge clock) disable iff (reset)
      (cmd.op != OP_LOAD) |=> (max_ff >= $past(max_ff)))
      else $error("running maximum decreased without a load");

   a_count_after_commit: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_COMMIT) |=> (cnt_ff != '0))
      else $error("step counter zero after a committed step");

endmodule

FILE: design/lorenz_euler_integrator.sv
// fixed-point lorenz system generator, forward-euler integration
//
// req channel: one item per command. req_tuser is the kind (0 = advance one
//   euler step, 1 = load start point, clear step count and running maximum).
//   req_tdata carries the start point for a load and is ignored on a step.
// rsp channel: exactly one item per request item, in order, with the point
//   after the item, the step count, sample and clip flags and the running
//   maximum squared distance to the start point.
// csr port: write-only, one register per cycle at csr_index; write only
//   while no item is in flight.
// timing: a step passes bz, sd, xr, dx, dy, commit and out; a distance sample
//   point adds sqx, sqy, sqz, sqsum and max; a load goes straight to out.
//   the rate is set by the dependent chain through one shared 33x33
//   multiplier (four coefficient products, three squares) and one
//   derivative-by-dt multiplier, one product per cycle.
// the result sits in an output register, so the next item is accepted while
//   it waits; if rsp_tready stays low the finished next result waits in the
//   datapath and no further item is accepted until the register frees.
// reset: point and start point go to (1.0, 1.0, 1.0), counters and maximum
//   clear, registers return to their default coefficients.
module lorenz_euler_integrator import lei_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [95:0]           req_tdata,   // start_x, start_y, start_z
   input  logic                  req_tuser,   // func
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [175:0]          rsp_tdata,   // pos_x, pos_y, pos_z, step_index,
                                              // max_sq_distance, zero fill
   output logic [1:0]            rsp_tuser,   // sampled, saturated
   // configuration port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
   logic [COUNT_W-1:0]        step_index;
   logic                      sampled, saturated;
   logic [SQ_W-1:0]           max_sq_distance;

   lei_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lei_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lei_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .start_x         ($signed(req_tdata[31:0])),
      .start_y         ($signed(req_tdata[63:32])),
      .start_z         ($signed(req_tdata[95:64])),
      .status          (status),
      .pos_x           (pos_x),
      .pos_y           (pos_y),
      .pos_z           (pos_z),
      .step_index      (step_index),
      .sampled         (sampled),
      .saturated       (saturated),
      .max_sq_distance (max_sq_distance)
   );

   // pack result fields, lowest first, zero fill to whole bytes
   assign rsp_tdata = {7'd0, max_sq_distance, step_index, pos_z, pos_y, pos_x};
   assign rsp_tuser = {saturated, sampled};

endmodule
